// ===== rtl/ssd_pkg.sv =====
// Shared types and constants for the streaming standard deviation block.
`timescale 1ns / 1ps

package ssd_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int MEAN_BITS          = 16;
   localparam int VALUE_BITS         = 32;
   localparam int SQUARE_BITS        = 49;
   localparam int DEV_BITS           = 16;
   localparam int QUOT_BITS          = 2 * DEV_BITS;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int COUNT_BITS_MAX     = 24;
   localparam int DIFF_BITS          = ((SAMPLE_BITS > MEAN_BITS) ? SAMPLE_BITS : MEAN_BITS) + 1;
   localparam int SQ_TERM_BITS       = 2 * DIFF_BITS;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 16;

   localparam logic [DEV_BITS-1:0] DEV_MAX = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIVIDE_BY_N_MINUS_ONE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_GIVEN_MEAN        = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GIVEN_MEAN            = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } req_payload_type;

   typedef struct packed {
      logic [DEV_BITS-1:0] deviation;
      logic                too_few_samples;
      logic                overflowed;
   } rsp_payload_type;

   typedef struct packed {
      logic                        divide_by_n_minus_one;
      logic                        use_given_mean;
      logic signed [MEAN_BITS-1:0] given_mean;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_BITS_MAX-1:0]    count;
      logic signed [VALUE_BITS-1:0] value;
      logic [SQUARE_BITS-1:0]       square;
      logic                         sample_mode;
      logic                         mean_mode;
      logic                         too_few_samples;
      logic                         overflowed;
   } job_type;

endpackage

// ===== rtl/ssd_front.sv =====
// Front end: squares each sample less any given mean, accumulates, queues finished sets.
`timescale 1ns / 1ps

module ssd_front #(
   parameter int COUNT_BITS = ssd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ssd_pkg::req_payload_type req_payload,
   input  ssd_pkg::cfg_type         cfg,
   input  logic                     job_room,
   output logic                     job_push,
   output ssd_pkg::job_type         job_data
);

   localparam int VB   = ssd_pkg::VALUE_BITS;
   localparam int SB   = ssd_pkg::SQUARE_BITS;
   localparam int DB   = ssd_pkg::DIFF_BITS;
   localparam int TB   = ssd_pkg::SQ_TERM_BITS;
   localparam int VSUM = VB + 1;
   localparam int SSUM = SB + 1;

   // square stage
   logic                                  a_valid_ff;
   logic [TB-1:0]                         a_sq_ff;
   logic signed [ssd_pkg::SAMPLE_BITS-1:0] a_x_ff;
   logic                                  a_mean_ff;
   logic                                  a_last_ff;
   logic                                  a_go;

   logic signed [ssd_pkg::MEAN_BITS-1:0]  mean_sel;
   logic signed [DB-1:0]                  diff;
   logic signed [TB-1:0]                  sq_term;

   // accumulators
   logic [COUNT_BITS-1:0]                 count_ff;
   logic [COUNT_BITS-1:0]                 count_nx;
   logic signed [VB-1:0]                  value_ff;
   logic signed [VB-1:0]                  value_nx;
   logic [SB-1:0]                         square_ff;
   logic [SB-1:0]                         square_nx;
   logic                                  sat_ff;
   logic                                  sat_nx;
   logic                                  count_full;
   logic signed [VSUM-1:0]                value_sum;
   logic                                  value_ovf;
   logic [SSUM-1:0]                       square_sum;
   logic                                  square_ovf;

   always_comb begin
      if (cfg.use_given_mean) begin
         mean_sel = cfg.given_mean;
      end else begin
         mean_sel = '0;
      end
   end

   assign diff    = DB'($signed(mean_sel)) - DB'($signed(req_payload.sample));
   assign sq_term = TB'(diff) * TB'(diff);

   assign a_go      = a_valid_ff && (!a_last_ff || job_room);
   assign req_ready = !a_valid_ff || a_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_sq_ff   <= $unsigned(sq_term);
         a_x_ff    <= req_payload.sample;
         a_mean_ff <= cfg.use_given_mean;
         a_last_ff <= req_payload.last;
      end
   end

   assign count_full = &count_ff;
   assign count_nx   = count_full ? count_ff : count_ff + COUNT_BITS'(1);

   assign value_sum = VSUM'($signed(value_ff)) + VSUM'($signed(a_x_ff));
   assign value_ovf = value_sum[VB] != value_sum[VB-1];

   assign square_sum = {1'b0, square_ff} + SSUM'(a_sq_ff);
   assign square_ovf = square_sum[SB];

   always_comb begin
      if (a_mean_ff) begin
         value_nx = value_ff;
      end else if (value_ovf) begin
         value_nx = {value_sum[VB], {(VB-1){~value_sum[VB]}}};
      end else begin
         value_nx = value_sum[VB-1:0];
      end
      if (square_ovf) begin
         square_nx = '1;
      end else begin
         square_nx = square_sum[SB-1:0];
      end
      sat_nx = sat_ff || count_full || (!a_mean_ff && value_ovf) || square_ovf;
   end

   assign job_push = a_go && a_last_ff;

   always_comb begin
      job_data.count           = ssd_pkg::COUNT_BITS_MAX'(count_nx);
      job_data.value           = value_nx;
      job_data.square          = square_nx;
      job_data.sample_mode     = cfg.divide_by_n_minus_one;
      job_data.mean_mode       = cfg.use_given_mean;
      job_data.too_few_samples = cfg.divide_by_n_minus_one && (count_nx < COUNT_BITS'(2));
      job_data.overflowed      = sat_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         value_ff  <= '0;
         square_ff <= '0;
         sat_ff    <= 1'b0;
      end else if (a_go) begin
         if (a_last_ff) begin
            count_ff  <= '0;
            value_ff  <= '0;
            square_ff <= '0;
            sat_ff    <= 1'b0;
         end else begin
            count_ff  <= count_nx;
            value_ff  <= value_nx;
            square_ff <= square_nx;
            sat_ff    <= sat_nx;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      job_push |=> (count_ff == '0 && value_ff == '0 && square_ff == '0 && !sat_ff))
      else $error("accumulators not cleared after end of set");

endmodule

// ===== rtl/ssd_queue.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module ssd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssd_pkg::job_type push_data,
   output logic             room,
   input  logic             pop,
   output logic             filled,
   output ssd_pkg::job_type head
);

   localparam int DEPTH = ssd_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   ssd_pkg::job_type entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    level_ff;

   assign room   = level_ff != CW'(DEPTH);
   assign filled = level_ff != '0;
   assign head   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + CW'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - CW'(1);
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> room)
      else $error("transfer into full job queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> filled)
      else $error("job taken from empty queue");

endmodule

// ===== rtl/ssd_back.sv =====
// Back end: sequential multiply, divide and square root for one set, plus the result register.
`timescale 1ns / 1ps

module ssd_back #(
   parameter int COUNT_BITS = ssd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   input  ssd_pkg::job_type         job_data,
   output logic                     job_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ssd_pkg::rsp_payload_type rsp_payload
);

   localparam int VB   = ssd_pkg::VALUE_BITS;
   localparam int SB   = ssd_pkg::SQUARE_BITS;
   localparam int QB   = ssd_pkg::QUOT_BITS;
   localparam int NW   = (COUNT_BITS + SB > 2 * VB) ? COUNT_BITS + SB : 2 * VB;
   localparam int HW   = NW - QB;
   localparam int DW2  = 2 * COUNT_BITS;
   localparam int CMPW = (HW > DW2) ? HW : DW2;
   localparam int CIW  = $clog2(COUNT_BITS);
   localparam int QIW  = $clog2(QB);
   localparam int RIW  = $clog2(ssd_pkg::DEV_BITS);
   localparam int CNTW = (CIW > QIW) ? CIW : QIW;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PREP  = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_SUB   = 8'b0000_1000,
      ST_CHECK = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_ROOT  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } back_state_type;

   back_state_type           state_ff;
   ssd_pkg::job_type         job_ff;
   logic [NW-1:0]            num_ff;
   logic [2*VB-1:0]          sq_ff;
   logic [DW2-1:0]           den_ff;
   logic [DW2-1:0]           rem_ff;
   logic [QB-1:0]            quot_ff;
   logic [QB-1:0]            root_ff;
   logic [CNTW-1:0]          cnt_ff;
   logic                     rsp_valid_ff;
   ssd_pkg::rsp_payload_type rsp_ff;

   logic [COUNT_BITS-1:0]    n;
   logic [COUNT_BITS-1:0]    n_sel;
   logic [DW2-1:0]           den_prod;
   logic [VB-1:0]            mag;
   logic [2*VB-1:0]          sq_prod;
   logic [NW-1:0]            mul_add;
   logic [HW-1:0]            hi_part;
   logic                     quot_sat;
   logic [DW2:0]             div_trial;
   logic [DW2:0]             div_diff;
   logic                     div_fit;
   logic [QB-1:0]            root_bit;
   logic [QB:0]              root_trial;
   logic                     root_fit;
   logic                     rsp_load;

   assign n        = job_ff.count[COUNT_BITS-1:0];
   assign n_sel    = job_ff.sample_mode ? n - COUNT_BITS'(1) : n;
   assign den_prod = DW2'(n) * DW2'(n_sel);
   assign mag      = job_ff.value[VB-1] ? VB'($unsigned(-$signed(job_ff.value)))
                                        : VB'($unsigned(job_ff.value));
   assign sq_prod  = (2*VB)'(mag) * (2*VB)'(mag);
   assign mul_add  = n[cnt_ff[CIW-1:0]] ? NW'(job_ff.square) : '0;

   assign hi_part  = num_ff[NW-1:QB];
   assign quot_sat = CMPW'(hi_part) >= CMPW'(den_ff);

   assign div_trial = {rem_ff, num_ff[cnt_ff[QIW-1:0]]};
   assign div_fit   = div_trial >= {1'b0, den_ff};
   assign div_diff  = div_trial - {1'b0, den_ff};

   assign root_bit   = QB'(1) << {cnt_ff[RIW-1:0], 1'b0};
   assign root_trial = {1'b0, root_ff} + {1'b0, root_bit};
   assign root_fit   = {1'b0, quot_ff} >= root_trial;

   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  if (job_data.too_few_samples || job_data.overflowed) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_PREP;
                  end
               end
            end
            ST_PREP: begin
               state_ff <= job_ff.mean_mode ? ST_CHECK : ST_MUL;
            end
            ST_MUL: begin
               if (cnt_ff == '0) begin
                  state_ff <= ST_SUB;
               end
            end
            ST_SUB: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               state_ff <= quot_sat ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == '0) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (cnt_ff == '0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_ff  <= job_data;
               root_ff <= '0;
            end
         end
         ST_PREP: begin
            sq_ff  <= sq_prod;
            cnt_ff <= CNTW'(COUNT_BITS - 1);
            if (job_ff.mean_mode) begin
               den_ff <= DW2'(n_sel);
               num_ff <= NW'(job_ff.square);
            end else begin
               den_ff <= den_prod;
               num_ff <= '0;
            end
         end
         ST_MUL: begin
            num_ff <= (num_ff << 1) + mul_add;
            cnt_ff <= cnt_ff - CNTW'(1);
         end
         ST_SUB: begin
            num_ff <= (num_ff >= NW'(sq_ff)) ? num_ff - NW'(sq_ff) : '0;
         end
         ST_CHECK: begin
            rem_ff  <= DW2'(hi_part);
            quot_ff <= '0;
            cnt_ff  <= CNTW'(QB - 1);
            if (quot_sat) begin
               root_ff <= QB'(ssd_pkg::DEV_MAX);
            end
         end
         ST_DIV: begin
            rem_ff  <= div_fit ? div_diff[DW2-1:0] : div_trial[DW2-1:0];
            quot_ff <= {quot_ff[QB-2:0], div_fit};
            if (cnt_ff == '0) begin
               cnt_ff  <= CNTW'(ssd_pkg::DEV_BITS - 1);
               root_ff <= '0;
            end else begin
               cnt_ff <= cnt_ff - CNTW'(1);
            end
         end
         ST_ROOT: begin
            if (root_fit) begin
               quot_ff <= quot_ff - root_trial[QB-1:0];
               root_ff <= (root_ff >> 1) + root_bit;
            end else begin
               root_ff <= root_ff >> 1;
            end
            cnt_ff <= cnt_ff - CNTW'(1);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.deviation       <= root_ff[ssd_pkg::DEV_BITS-1:0];
         rsp_ff.too_few_samples <= job_ff.too_few_samples;
         rsp_ff.overflowed      <= job_ff.overflowed;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.too_few_samples || rsp_ff.overflowed)) |->
         rsp_ff.deviation == '0)
      else $error("flagged result with nonzero deviation");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> den_ff != '0)
      else $error("divide started with zero divisor");

endmodule

// ===== rtl/streaming_standard_deviation_top.sv =====
// Top level of the streaming standard deviation block: CSRs, front end, job queue, back end.
`timescale 1ns / 1ps
//
// channel  dir  handshake             payload
// req      in   req_valid, req_ready  ssd_pkg::req_payload_type (sample, last)
// rsp      out  rsp_valid, rsp_ready  ssd_pkg::rsp_payload_type (deviation, flags)
// csr      in   csr_valid, csr_ready  csr_index, csr_data
//
// One sample per cycle through a square stage and an accumulate stage, while the front is not stalled.
// A set's result follows its last sample transfer through a shift-add multiply over the count
// bits (skipped with the given mean), a 32-step divide and a 16-step root.
// Flagged sets skip the arithmetic and go straight from the job queue to the result register.
// The two-entry job queue lets the front run on;
// it stalls only when a last sample meets a full queue. Synchronous reset, no clearing pass.

module streaming_standard_deviation_top #(
   parameter int COUNT_BITS = ssd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ssd_pkg::req_payload_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ssd_pkg::rsp_payload_type              rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ssd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ssd_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   ssd_pkg::cfg_type cfg_ff;
   ssd_pkg::job_type push_data;
   ssd_pkg::job_type head;
   logic             job_push;
   logic             job_room;
   logic             job_pop;
   logic             job_filled;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divide_by_n_minus_one <= 1'b1;
         cfg_ff.use_given_mean        <= 1'b0;
         cfg_ff.given_mean            <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ssd_pkg::CSR_DIVIDE_BY_N_MINUS_ONE: begin
               cfg_ff.divide_by_n_minus_one <= csr_data[0];
            end
            ssd_pkg::CSR_USE_GIVEN_MEAN: begin
               cfg_ff.use_given_mean <= csr_data[0];
            end
            ssd_pkg::CSR_GIVEN_MEAN: begin
               cfg_ff.given_mean <= $signed(csr_data[ssd_pkg::MEAN_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   ssd_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .job_room    (job_room),
      .job_push    (job_push),
      .job_data    (push_data)
   );

   ssd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .room      (job_room),
      .pop       (job_pop),
      .filled    (job_filled),
      .head      (head)
   );

   ssd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_filled),
      .job_data    (head),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
